// ===== design/mml_pkg.sv =====
// Shared types and constants for the MML note sequencer.
// Depends on nothing; used by every module of the block.
`default_nettype none
package mml_pkg;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_NUM  = 2'd1;
   localparam logic [1:0] PH_MODE = 2'd2;
   localparam logic [1:0] PH_LEN  = 2'd3;

   localparam logic [2:0] PK_NONE  = 3'd0;
   localparam logic [2:0] PK_TEMPO = 3'd1;
   localparam logic [2:0] PK_OCT   = 3'd2;
   localparam logic [2:0] PK_LEN   = 3'd3;
   localparam logic [2:0] PK_ABS   = 3'd4;
   localparam logic [2:0] PK_NOTE  = 3'd5;
   localparam logic [2:0] PK_REST  = 3'd6;

   localparam logic [9:0] ACC_MAX = 10'd1023;

   // one note job handed from the parser to the timing unit
   typedef struct packed {
      logic [12:0] freq_hz;
      logic [7:0]  tempo;
      logic [6:0]  len;
      logic        dotted;
      logic        fg;
   } job_type;

   // trunc(440 * 2^((m-69)/12)) for midi m = 11..96, zero elsewhere
   function automatic logic [12:0] rom_hz(input logic [6:0] midi);
      logic [12:0] r;
      begin
         r = 13'd0;
         case (midi)
            7'd11: r = 13'd15;   7'd12: r = 13'd16;   7'd13: r = 13'd17;
            7'd14: r = 13'd18;   7'd15: r = 13'd19;   7'd16: r = 13'd20;
            7'd17: r = 13'd21;   7'd18: r = 13'd23;   7'd19: r = 13'd24;
            7'd20: r = 13'd25;   7'd21: r = 13'd27;   7'd22: r = 13'd29;
            7'd23: r = 13'd30;   7'd24: r = 13'd32;   7'd25: r = 13'd34;
            7'd26: r = 13'd36;   7'd27: r = 13'd38;   7'd28: r = 13'd41;
            7'd29: r = 13'd43;   7'd30: r = 13'd46;   7'd31: r = 13'd48;
            7'd32: r = 13'd51;   7'd33: r = 13'd55;   7'd34: r = 13'd58;
            7'd35: r = 13'd61;   7'd36: r = 13'd65;   7'd37: r = 13'd69;
            7'd38: r = 13'd73;   7'd39: r = 13'd77;   7'd40: r = 13'd82;
            7'd41: r = 13'd87;   7'd42: r = 13'd92;   7'd43: r = 13'd97;
            7'd44: r = 13'd103;  7'd45: r = 13'd110;  7'd46: r = 13'd116;
            7'd47: r = 13'd123;  7'd48: r = 13'd130;  7'd49: r = 13'd138;
            7'd50: r = 13'd146;  7'd51: r = 13'd155;  7'd52: r = 13'd164;
            7'd53: r = 13'd174;  7'd54: r = 13'd184;  7'd55: r = 13'd195;
            7'd56: r = 13'd207;  7'd57: r = 13'd220;  7'd58: r = 13'd233;
            7'd59: r = 13'd246;  7'd60: r = 13'd261;  7'd61: r = 13'd277;
            7'd62: r = 13'd293;  7'd63: r = 13'd311;  7'd64: r = 13'd329;
            7'd65: r = 13'd349;  7'd66: r = 13'd369;  7'd67: r = 13'd391;
            7'd68: r = 13'd415;  7'd69: r = 13'd440;  7'd70: r = 13'd466;
            7'd71: r = 13'd493;  7'd72: r = 13'd523;  7'd73: r = 13'd554;
            7'd74: r = 13'd587;  7'd75: r = 13'd622;  7'd76: r = 13'd659;
            7'd77: r = 13'd698;  7'd78: r = 13'd739;  7'd79: r = 13'd783;
            7'd80: r = 13'd830;  7'd81: r = 13'd880;  7'd82: r = 13'd932;
            7'd83: r = 13'd987;  7'd84: r = 13'd1046; 7'd85: r = 13'd1108;
            7'd86: r = 13'd1174; 7'd87: r = 13'd1244; 7'd88: r = 13'd1318;
            7'd89: r = 13'd1396; 7'd90: r = 13'd1479; 7'd91: r = 13'd1567;
            7'd92: r = 13'd1661; 7'd93: r = 13'd1760; 7'd94: r = 13'd1864;
            7'd95: r = 13'd1975; 7'd96: r = 13'd2093;
            default: r = 13'd0;
         endcase
         return r;
      end
   endfunction

   // semitone within the octave for letters A..G
   function automatic logic [3:0] letter_semi(input logic [2:0] idx);
      logic [3:0] r;
      begin
         case (idx)
            3'd0: r = 4'd9;
            3'd1: r = 4'd11;
            3'd2: r = 4'd0;
            3'd3: r = 4'd2;
            3'd4: r = 4'd4;
            3'd5: r = 4'd5;
            3'd6: r = 4'd7;
            default: r = 4'd0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ===== design/mml_note_sequencer_core.sv =====
// MML note sequencer top level: parser, job queue and duration timer.
// Throughput: one character per cycle unless the job queue is full (req_stall).
// The bit-serial duration divider (19 quotient bits) finishes one note before it
// takes the next from the queue. A two-job queue decouples.
// Reset (synchronous) restores tempo 120, octave 4, length 4, background.
`default_nettype none
module mml_note_sequencer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [12:0]      rsp_freq_hz,
   output logic [13:0]      rsp_duration_ms,
   output logic             rsp_wait_for_end
);

   logic             push, full, pop, not_empty;
   mml_pkg::job_type pjob, hjob;

   mml_parser u_parser (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_char_code,
      .job_valid(push), .job(pjob), .job_full(full)
   );

   mml_job_queue u_queue (
      .clock, .reset, .push, .push_job(pjob), .full, .pop,
      .not_empty, .head(hjob)
   );

   mml_timer u_timer (
      .clock, .reset, .job_ready(not_empty), .job(hjob), .job_pop(pop),
      .rsp_valid, .rsp_stall, .rsp_freq_hz, .rsp_duration_ms, .rsp_wait_for_end
   );

endmodule
`default_nettype wire

// ===== design/mml_parser.sv =====
// Front end: parses MML characters, keeps the settings, issues note jobs.
// Depends on mml_pkg.
`default_nettype none
module mml_parser (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic            req_command,
   input  wire logic [7:0]      req_char_code,
   output logic                 job_valid,
   output mml_pkg::job_type     job,
   input  wire logic            job_full
);

   logic [7:0] tempo_ff, tempo_in;
   logic [2:0] oct_ff, oct_in;
   logic [6:0] dlen_ff, dlen_in;
   logic       fg_ff, fg_in;
   logic [1:0] phase_ff, phase_in;
   logic [2:0] kind_ff, kind_in;
   logic       acc_phase_ff, acc_phase_in; // accidental still allowed
   logic signed [5:0] semi_ff, semi_in;
   logic [9:0] acc_ff, acc_in;

   logic [7:0]  c, u;
   logic        blank, digit, take;
   logic [13:0] acc_x10;
   logic [6:0]  nlen;
   logic [6:0]  midi_note;
   logic signed [7:0] midi_s;
   logic [12:0] note_hz;

   assign req_stall = job_full;
   assign take      = req_valid && !job_full;
   assign c         = req_char_code;
   assign u         = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
   assign blank     = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   assign digit     = (c >= 8'd48 && c <= 8'd57);
   assign acc_x10   = {4'd0, acc_ff} * 14'd10 + {10'd0, c[3:0] - 4'd0};
   assign nlen      = (acc_ff >= 10'd1 && acc_ff <= 10'd64) ? acc_ff[6:0] : dlen_ff;
   assign midi_s    = 8'(signed'({1'b0, ({4'd0, oct_ff} + 7'd1) * 7'd12})) + 8'(semi_ff);
   assign midi_note = midi_s[7] ? 7'd0 : midi_s[6:0];
   assign note_hz   = (kind_ff == mml_pkg::PK_NOTE) ? mml_pkg::rom_hz(midi_note) : 13'd0;

   always_comb begin
      logic fin_num, fin_note, dot, start;
      tempo_in = tempo_ff; oct_in = oct_ff; dlen_in = dlen_ff; fg_in = fg_ff;
      phase_in = phase_ff; kind_in = kind_ff; acc_phase_in = acc_phase_ff;
      semi_in = semi_ff; acc_in = acc_ff;
      job_valid = 1'b0;
      job = '0;
      job.tempo = tempo_ff;
      job.fg = fg_ff;
      fin_num = 1'b0; fin_note = 1'b0; dot = 1'b0; start = 1'b0;
      if (take) begin
         if (req_command) begin
            fin_num  = (phase_ff == mml_pkg::PH_NUM);
            fin_note = (phase_ff == mml_pkg::PH_LEN);
         end else begin
            case (phase_ff)
               mml_pkg::PH_NUM: begin
                  if (digit) acc_in = acc_x10 > 14'd1023 ? mml_pkg::ACC_MAX : acc_x10[9:0];
                  else begin fin_num = 1'b1; start = 1'b1; end
               end
               mml_pkg::PH_MODE: begin
                  if (u == 8'h42) fg_in = 1'b0;
                  else if (u == 8'h46) fg_in = 1'b1;
                  phase_in = mml_pkg::PH_IDLE;
               end
               mml_pkg::PH_LEN: begin
                  acc_phase_in = 1'b0;
                  if (acc_phase_ff && (c == 8'h2B || c == 8'h23)) semi_in = semi_ff + 6'sd1;
                  else if (acc_phase_ff && c == 8'h2D) semi_in = semi_ff - 6'sd1;
                  else if (digit)
                     acc_in = acc_x10 > 14'd1023 ? mml_pkg::ACC_MAX : acc_x10[9:0];
                  else if (c == 8'h2E) begin fin_note = 1'b1; dot = 1'b1; end
                  else begin fin_note = 1'b1; start = 1'b1; end
               end
               default: begin
                  kind_in = mml_pkg::PK_NONE;
                  start = 1'b1;
               end
            endcase
         end
         if (fin_note) begin
            job_valid = 1'b1;
            job.freq_hz = note_hz;
            job.len = nlen;
            job.dotted = dot;
            phase_in = mml_pkg::PH_IDLE;
            kind_in = mml_pkg::PK_NONE;
         end
         if (fin_num) begin
            phase_in = mml_pkg::PH_IDLE;
            kind_in = mml_pkg::PK_NONE;
            case (kind_ff)
               mml_pkg::PK_TEMPO: if (acc_ff >= 10'd32 && acc_ff <= 10'd255) tempo_in = acc_ff[7:0];
               mml_pkg::PK_OCT: if (acc_ff <= 10'd6) oct_in = acc_ff[2:0];
               mml_pkg::PK_LEN: if (acc_ff >= 10'd1 && acc_ff <= 10'd64) dlen_in = acc_ff[6:0];
               mml_pkg::PK_ABS: begin
                  job.len = dlen_ff;
                  if (acc_ff == 10'd0) job_valid = 1'b1;
                  else if (acc_ff <= 10'd84) begin
                     job_valid = 1'b1;
                     job.freq_hz = mml_pkg::rom_hz(acc_ff[6:0] + 7'd11);
                  end
               end
               default: ;
            endcase
         end
         if (start) begin
            acc_in = 10'd0;
            if (!blank) begin
               if (u == 8'h54 || u == 8'h4F || u == 8'h4C || u == 8'h4E) begin
                  phase_in = mml_pkg::PH_NUM;
                  kind_in = (u == 8'h54) ? mml_pkg::PK_TEMPO : (u == 8'h4F) ? mml_pkg::PK_OCT
                          : (u == 8'h4C) ? mml_pkg::PK_LEN : mml_pkg::PK_ABS;
               end else if (u == 8'h4D) phase_in = mml_pkg::PH_MODE;
               else if (u == 8'h3C) begin
                  if (oct_in > 3'd0) oct_in = oct_in - 3'd1;
               end else if (u == 8'h3E) begin
                  if (oct_in < 3'd6) oct_in = oct_in + 3'd1;
               end else if (u >= 8'h41 && u <= 8'h47) begin
                  semi_in = 6'(mml_pkg::letter_semi(3'(u - 8'h41)));
                  kind_in = mml_pkg::PK_NOTE;
                  phase_in = mml_pkg::PH_LEN;
                  acc_phase_in = 1'b1;
               end else if (u == 8'h50) begin
                  semi_in = 6'sd0;
                  kind_in = mml_pkg::PK_REST;
                  phase_in = mml_pkg::PH_LEN;
                  acc_phase_in = 1'b0;
               end
            end
         end
         if (req_command) begin
            tempo_in = 8'd120; oct_in = 3'd4; dlen_in = 7'd4; fg_in = 1'b0;
            phase_in = mml_pkg::PH_IDLE; kind_in = mml_pkg::PK_NONE;
            semi_in = 6'sd0; acc_in = 10'd0; acc_phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff <= 8'd120; oct_ff <= 3'd4; dlen_ff <= 7'd4; fg_ff <= 1'b0;
         phase_ff <= mml_pkg::PH_IDLE; kind_ff <= mml_pkg::PK_NONE;
         acc_phase_ff <= 1'b0; semi_ff <= 6'sd0; acc_ff <= 10'd0;
      end else begin
         tempo_ff <= tempo_in; oct_ff <= oct_in; dlen_ff <= dlen_in; fg_ff <= fg_in;
         phase_ff <= phase_in; kind_ff <= kind_in; acc_phase_ff <= acc_phase_in;
         semi_ff <= semi_in; acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/mml_job_queue.sv =====
// Two-entry queue of note jobs between parser and timing unit.
// Depends on mml_pkg.
`default_nettype none
module mml_job_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire mml_pkg::job_type push_job,
   output logic                 full,
   input  wire logic            pop,
   output logic                 not_empty,
   output mml_pkg::job_type     head
);

   mml_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_job;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule
`default_nettype wire

// ===== design/mml_timer.sv =====
// Back end: duration divider (restoring, one quotient bit per cycle)
// and the result register. Depends on mml_pkg.
`default_nettype none
module mml_timer (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            job_ready,
   input  wire mml_pkg::job_type job,
   output logic                 job_pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [12:0]          rsp_freq_hz,
   output logic [13:0]          rsp_duration_ms,
   output logic                 rsp_wait_for_end
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  st_ff, st_in;
   logic [18:0] rem_ff, rem_in;   // partial remainder; the dividend shifts out of num_ff
   logic [18:0] quo_ff, quo_in;
   logic [14:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [12:0] hz_ff, hz_in;
   logic        fg_ff, fg_in;
   logic [18:0] num_ff, num_in;
   logic [33:0] trial;

   assign job_pop          = (st_ff == ST_IDLE) && job_ready;
   assign rsp_valid        = (st_ff == ST_OUT);
   assign rsp_freq_hz      = hz_ff;
   assign rsp_duration_ms  = quo_ff[13:0];
   assign rsp_wait_for_end = fg_ff;
   assign trial = {15'd0, rem_ff[17:0], num_ff[18]} - {19'd0, den_ff};

   always_comb begin
      st_in = st_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; hz_in = hz_ff; fg_in = fg_ff; num_in = num_ff;
      case (st_ff)
         ST_IDLE: if (job_ready) begin
            // 240000*k/(tempo*len), k = 1, or 1.5 when dotted (numerator 360000)
            num_in = job.dotted ? 19'd360000 : 19'd240000;
            den_in = {7'd0, job.tempo} * {8'd0, job.len};
            hz_in = job.freq_hz;
            fg_in = job.fg;
            st_in = ST_MUL;
         end
         ST_MUL: begin
            rem_in = 19'd0; quo_in = 19'd0; cnt_in = 5'd19;
            st_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[33]) begin
               rem_in = trial[18:0];
               quo_in = {quo_ff[17:0], 1'b1};
            end else begin
               rem_in = {rem_ff[17:0], num_ff[18]};
               quo_in = {quo_ff[17:0], 1'b0};
            end
            num_in = {num_ff[17:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) st_in = ST_OUT;
         end
         ST_OUT: if (!rsp_stall) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; cnt_ff <= cnt_in;
      hz_ff <= hz_in; fg_ff <= fg_in; num_ff <= num_in;
   end

endmodule
`default_nettype wire
